// File: design/tea_pkg.sv
// Shared types, constants and the round mixing function for the TEA decryption block.
// No dependencies; used by every other file of the block.
`default_nettype none

package tea_pkg;

	localparam logic [31:0] TEA_DELTA  = 32'h9E37_79B9;
	localparam logic [31:0] TEA_START  = 32'hC6EF_3720;
	localparam int unsigned TEA_ROUNDS = 32;

	// key register reset seeds
	localparam logic [31:0] KEY0_RST = 32'h09F4_FBBD;
	localparam logic [31:0] KEY1_RST = 32'h9681_884A;
	localparam logic [31:0] KEY2_RST = 32'h3520_27E9;
	localparam logic [31:0] KEY3_RST = 32'hF3DE_E5A7;

	localparam int unsigned IDX_W = 2;

	typedef enum logic [IDX_W-1:0] {
		IDX_KEY0 = 2'd0,
		IDX_KEY1 = 2'd1,
		IDX_KEY2 = 2'd2,
		IDX_KEY3 = 2'd3
	} key_idx_t;

	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} key_t;

	typedef struct packed {
		logic skid_full;
	} skid_status_t;

	function automatic logic [31:0] tea_mix(input logic [31:0] w, input logic [31:0] acc,
			input logic [31:0] kl, input logic [31:0] kr);
		tea_mix = ((w << 4) + kl) ^ (w + acc) ^ ((w >> 5) + kr);
	endfunction

endpackage

`default_nettype wire

// File: design/tea_block_decrypt.sv
// Top level of the TEA block decryption engine: key registers, round pipeline, output stage.
// Depends on tea_pkg, tea_round and tea_out_skid.
`default_nettype none

// TEA decryption, 32 rounds, fully unrolled. One 64-bit block (cipher_first,
// cipher_second) is accepted per cycle while in_ready is high and yields
// exactly one plaintext pair, in order. Each round is split into two register
// stages (one half-round, i.e. one mix and one subtract, per stage), giving a
// 64-stage round pipeline followed by the output register; throughput is one
// transaction per cycle while in_ready is high. The pipeline moves as a whole
// and is held only while the output skid buffer is occupied: in_ready drops in
// the cycle after the output register stalls with a further result arriving
// behind it. The 128-bit key lives in four write-only registers (index 0..3 =
// k0..k3) that reset to the default seeds; they are read live by every stage,
// so write them only while the pipeline is empty.

module tea_block_decrypt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// cipher input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] cipher_first,
	input  wire logic [31:0] cipher_second,
	// plaintext output
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      plain_first,
	output logic [31:0]      plain_second,
	// key write port
	input  wire logic        wr_en,
	input  wire logic [tea_pkg::IDX_W-1:0] wr_index,
	input  wire logic [31:0] wr_data
);

	localparam int unsigned NR = tea_pkg::TEA_ROUNDS;

	tea_pkg::key_t         key_q;
	tea_pkg::skid_status_t skid_st;
	logic                  adv;

	logic [31:0] a_w [0:NR];
	logic [31:0] b_w [0:NR];
	logic [NR:0] v_w;

	// ---- key registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q.k0 <= tea_pkg::KEY0_RST;
			key_q.k1 <= tea_pkg::KEY1_RST;
			key_q.k2 <= tea_pkg::KEY2_RST;
			key_q.k3 <= tea_pkg::KEY3_RST;
		end else if (wr_en) begin
			case (tea_pkg::key_idx_t'(wr_index))
				tea_pkg::IDX_KEY0: key_q.k0 <= wr_data;
				tea_pkg::IDX_KEY1: key_q.k1 <= wr_data;
				tea_pkg::IDX_KEY2: key_q.k2 <= wr_data;
				tea_pkg::IDX_KEY3: key_q.k3 <= wr_data;
				default: ;
			endcase
		end
	end

	// ---- round pipeline ----
	// whole pipeline advances unless the skid buffer is holding a transaction
	assign adv      = !skid_st.skid_full;
	assign in_ready = adv;

	assign v_w[0] = in_valid;
	assign a_w[0] = cipher_first;
	assign b_w[0] = cipher_second;

	for (genvar r = 0; r < NR; r++) begin : g_round
		// round accumulator is a constant per round: start minus r deltas
		localparam logic [31:0] ACC = tea_pkg::TEA_START - 32'(r) * tea_pkg::TEA_DELTA;

		tea_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.acc       (ACC),
			.key       (key_q),
			.valid_in  (v_w[r]),
			.a_in      (a_w[r]),
			.b_in      (b_w[r]),
			.valid_out (v_w[r+1]),
			.a_out     (a_w[r+1]),
			.b_out     (b_w[r+1])
		);
	end

	// ---- output register and skid ----
	tea_out_skid u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.pipe_valid   (v_w[NR]),
		.pipe_first   (a_w[NR]),
		.pipe_second  (b_w[NR]),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.plain_first  (plain_first),
		.plain_second (plain_second),
		.status       (skid_st)
	);

	// ---- assertions ----
	// skid only fills behind a held output
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_st.skid_full |-> out_valid)
		else $error("skid buffer full with no valid output");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_st.skid_full) |-> $past(out_valid && !out_ready))
		else $error("skid buffer filled without an output stall");

	// a frozen pipeline must neither lose nor invent transactions
	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(v_w[NR:1]))
		else $error("pipeline valid bits moved while stalled");

endmodule

`default_nettype wire

// File: design/tea_round.sv
// One decryption round as two register stages, one half-round each.
// Depends on tea_pkg (key_t, tea_mix).
`default_nettype none

module tea_round (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [31:0]   acc,
	input  wire tea_pkg::key_t key,
	input  wire logic          valid_in,
	input  wire logic [31:0]   a_in,
	input  wire logic [31:0]   b_in,
	output logic               valid_out,
	output logic [31:0]        a_out,
	output logic [31:0]        b_out
);

	logic        valid_s1, valid_s2;
	logic [31:0] a_s1, b_s1, a_s2, b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// first half updates b from a, second half updates a from new b
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_in;
			b_s1 <= b_in - tea_pkg::tea_mix(a_in, acc, key.k2, key.k3);
			a_s2 <= a_s1 - tea_pkg::tea_mix(b_s1, acc, key.k0, key.k1);
			b_s2 <= b_s1;
		end
	end

	assign valid_out = valid_s2;
	assign a_out     = a_s2;
	assign b_out     = b_s2;

endmodule

`default_nettype wire

// File: design/tea_out_skid.sv
// Output register with a one-entry skid buffer behind the round pipeline.
// Depends on tea_pkg (skid_status_t).
`default_nettype none

module tea_out_skid (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pipe_valid,
	input  wire logic [31:0]          pipe_first,
	input  wire logic [31:0]          pipe_second,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic [31:0]               plain_first,
	output logic [31:0]               plain_second,
	output tea_pkg::skid_status_t     status
);

	logic        out_valid_q, skid_valid_q, load_out;
	logic [31:0] out_first_q, out_second_q, skid_first_q, skid_second_q;

	assign load_out = !out_valid_q || out_ready;

	// while the skid holds a transaction the pipeline is frozen and pipe_* is not consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q ? 1'b1 : pipe_valid;
			skid_valid_q <= 1'b0;
		end else if (!skid_valid_q && pipe_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_first_q  <= skid_valid_q ? skid_first_q  : pipe_first;
			out_second_q <= skid_valid_q ? skid_second_q : pipe_second;
		end else if (!skid_valid_q && pipe_valid) begin
			skid_first_q  <= pipe_first;
			skid_second_q <= pipe_second;
		end
	end

	assign out_valid        = out_valid_q;
	assign plain_first      = out_first_q;
	assign plain_second     = out_second_q;
	assign status.skid_full = skid_valid_q;

endmodule

`default_nettype wire
